// File: rtl/mwar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwar_pkg
// shared widths, reset values and codes of the window average reporter
// ----------------------------------------------------------------------------
package mwar_pkg;

  // fixed field widths
  localparam int TYPE_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int CHIDX_W   = 2;
  localparam int AVG_W     = 24;
  localparam int MSG_W     = 32;
  localparam int TICK_W    = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TYPE_W-1:0] BASE_RESET     = 8'd0;
  localparam logic [TICK_W-1:0] INTERVAL_RESET = 32'd1000000;

  // parameter defaults
  localparam int WINDOW_DEFAULT   = 16;
  localparam int CHANNELS_DEFAULT = 4;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    ITEM_SAMPLE = 1'b0,
    ITEM_TICK   = 1'b1
  } item_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_CHANNEL_TYPE = 1'b0,
    CFG_REPORT_INTERVAL   = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

// File: rtl/mwar_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwar_if
// valid/ready channels for sample beats and report beats
// ----------------------------------------------------------------------------
interface mwar_in_if;
  import mwar_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [TYPE_W-1:0]   type_code;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output mode, output type_code, output sample_value,
                  input ready);
  modport sink   (input valid, input mode, input type_code, input sample_value,
                  output ready);
endinterface

interface mwar_out_if;
  import mwar_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHIDX_W-1:0] channel_index;
  logic [AVG_W-1:0]   average_q8;
  logic [MSG_W-1:0]   total_messages;

  modport source (output valid, output channel_index, output average_q8,
                  output total_messages, input ready);
  modport sink   (input valid, input channel_index, input average_q8,
                  input total_messages, output ready);
endinterface
`default_nettype wire

// File: rtl/mwar_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwar_front
// accepts input beats, drops samples outside the channel range, packs the rest
// ----------------------------------------------------------------------------
module mwar_front #(
  parameter int CHANNELS = mwar_pkg::CHANNELS_DEFAULT,
  parameter int ENTRY_W  = 1 + 2 + mwar_pkg::SAMPLE_W
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_mode,
  input  wire logic [mwar_pkg::TYPE_W-1:0]   in_channel_type,
  input  wire logic [mwar_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic [mwar_pkg::TYPE_W-1:0]   base_channel_type,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [ENTRY_W-1:0]                 q_data
);
  import mwar_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TYPE_W:0] offset;
  logic            in_range;
  logic            is_tick;

  assign offset   = {1'b0, in_channel_type} - {1'b0, base_channel_type};
  assign in_range = !offset[TYPE_W] && (offset < (TYPE_W + 1)'(CHANNELS));
  assign is_tick  = item_kind_t'(in_mode) == ITEM_TICK;

  assign in_ready = !q_full;
  // out-of-range samples are taken and dropped here
  assign q_push   = in_valid && !q_full && (is_tick || in_range);
  assign q_data   = {in_mode, offset[CH_W-1:0], in_sample_value};

endmodule
`default_nettype wire

// File: rtl/mwar_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwar_queue
// short fifo between the classifier and the channel update pipeline
// ----------------------------------------------------------------------------
module mwar_queue #(
  parameter int DATA_W = 19,
  parameter int DEPTH  = mwar_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output logic [DATA_W-1:0]      pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue popped while empty");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");

  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("queue count lost a push");

endmodule
`default_nettype wire

// File: rtl/mwar_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwar_back
// per-channel window update, report decision and q8 average
// ----------------------------------------------------------------------------
module mwar_back #(
  parameter int WINDOW   = mwar_pkg::WINDOW_DEFAULT,
  parameter int CHANNELS = mwar_pkg::CHANNELS_DEFAULT,
  parameter int ENTRY_W  = 1 + 2 + mwar_pkg::SAMPLE_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire logic [ENTRY_W-1:0]           q_data,
  output logic                              q_pop,
  input  wire logic [mwar_pkg::TICK_W-1:0]  report_interval,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mwar_pkg::CHIDX_W-1:0]      out_channel_index,
  output logic [mwar_pkg::AVG_W-1:0]        out_average_q8,
  output logic [mwar_pkg::MSG_W-1:0]        out_total_messages
);
  import mwar_pkg::*;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W     = $clog2(WINDOW);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + POS_W;
  localparam int ADDR_W    = CH_W + POS_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  // average = floor(sum * 256 / WINDOW) = (sum * RECIP) >> SHIFT
  localparam int RECIP_L   = SUM_W + 8 + POS_W;
  localparam int SHIFT     = RECIP_L - 8;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_L) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP);

  // stage 1: channel counters and window ring
  logic                is_sample, is_tick, adv;
  item_kind_t          item_kind;
  logic [CH_W-1:0]     item_ch;
  logic [SAMPLE_W-1:0] item_value;

  logic [POS_W-1:0]  pos_r   [CHANNELS];
  logic [FILL_W-1:0] fill_r  [CHANNELS];
  logic [POS_W-1:0]  phase_r [CHANNELS];
  logic [MSG_W-1:0]  msg_r   [CHANNELS];
  logic [TICK_W-1:0] ticks_r [CHANNELS];
  logic [TICK_W-1:0] ticks_nxt [CHANNELS];
  logic [SUM_W-1:0]  sum_r   [CHANNELS];

  logic [SAMPLE_W-1:0] win_mem [MEM_DEPTH];
  logic [ADDR_W-1:0]   win_addr;

  logic [POS_W-1:0]  cur_pos, pos_nxt, cur_phase, phase_nxt;
  logic [FILL_W-1:0] cur_fill, fill_nxt;
  logic [MSG_W-1:0]  cur_msg, msg_nxt;
  logic              full_old, report;

  // stage 2: running sum
  logic                s2_valid_r, s2_full_r, s2_report_r;
  logic [CH_W-1:0]     s2_ch_r;
  logic [SAMPLE_W-1:0] s2_value_r, old_sample_r;
  logic [MSG_W-1:0]    s2_msg_r;
  logic [SUM_W-1:0]    sum_nxt;

  // stage 3: average multiply
  logic             s3_valid_r;
  logic [CH_W-1:0]  s3_ch_r;
  logic [SUM_W-1:0] s3_sum_r;
  logic [MSG_W-1:0] s3_msg_r;
  logic [PROD_W-1:0] prod;

  // output register
  logic             out_valid_r;
  logic [CH_W-1:0]  out_ch_r;
  logic [AVG_W-1:0] out_avg_r;
  logic [MSG_W-1:0] out_msg_r;
  logic [31:0]      out_ch_wide;

  assign adv        = !out_valid_r || out_ready;
  assign q_pop      = adv && q_valid;
  assign item_kind  = item_kind_t'(q_data[ENTRY_W-1]);
  assign item_ch    = q_data[SAMPLE_W +: CH_W];
  assign item_value = q_data[SAMPLE_W-1:0];
  assign is_sample  = q_pop && (item_kind == ITEM_SAMPLE);
  assign is_tick    = q_pop && (item_kind == ITEM_TICK);

  always_comb begin
    cur_pos   = pos_r[item_ch];
    cur_fill  = fill_r[item_ch];
    cur_phase = phase_r[item_ch];
    cur_msg   = msg_r[item_ch];
    full_old  = cur_fill == FILL_W'(WINDOW);
    fill_nxt  = full_old ? cur_fill : cur_fill + 1'b1;
    pos_nxt   = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
    msg_nxt   = cur_msg + 1'b1;
    // phase follows message count mod window, including the 2^32 wrap
    phase_nxt = (msg_nxt == '0 || cur_phase == POS_W'(WINDOW - 1)) ? '0
                                                                   : cur_phase + 1'b1;
    report    = (fill_nxt == FILL_W'(WINDOW)) &&
                (phase_nxt == '0 || ticks_r[item_ch] >= report_interval);
    win_addr  = {item_ch, cur_pos};
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ticks_nxt[c] = ticks_r[c];
      if (is_tick && ticks_r[c] != '1) begin
        ticks_nxt[c] = ticks_r[c] + 1'b1;
      end
      if (is_sample && report && CH_W'(c) == item_ch) begin
        ticks_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]   <= '0;
        fill_r[c]  <= '0;
        phase_r[c] <= '0;
        msg_r[c]   <= '0;
        ticks_r[c] <= '0;
      end
    end else begin
      ticks_r <= ticks_nxt;
      if (is_sample) begin
        pos_r[item_ch]   <= pos_nxt;
        fill_r[item_ch]  <= fill_nxt;
        phase_r[item_ch] <= phase_nxt;
        msg_r[item_ch]   <= msg_nxt;
      end
    end
  end

  // read-first ring: the evicted sample comes out as the new one goes in
  always_ff @(posedge clk) begin
    if (is_sample) begin
      old_sample_r      <= win_mem[win_addr];
      win_mem[win_addr] <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      s2_ch_r     <= item_ch;
      s2_value_r  <= item_value;
      s2_full_r   <= full_old;
      s2_report_r <= report;
      s2_msg_r    <= msg_nxt;
    end
  end

  assign sum_nxt = sum_r[s2_ch_r] - (s2_full_r ? SUM_W'(old_sample_r) : '0)
                   + SUM_W'(s2_value_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_r[c] <= '0;
      end
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      if (s2_valid_r) begin
        sum_r[s2_ch_r] <= sum_nxt;
      end
      s3_valid_r <= s2_valid_r && s2_report_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      s3_ch_r  <= s2_ch_r;
      s3_sum_r <= sum_nxt;
      s3_msg_r <= s2_msg_r;
    end
  end

  assign prod = PROD_W'(s3_sum_r) * PROD_W'(RECIP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      out_ch_r  <= s3_ch_r;
      out_avg_r <= prod[SHIFT +: AVG_W];
      out_msg_r <= s3_msg_r;
    end
  end

  assign out_ch_wide        = 32'(out_ch_r);
  assign out_valid          = out_valid_r;
  assign out_channel_index  = out_ch_wide[CHIDX_W-1:0];
  assign out_average_q8     = out_avg_r;
  assign out_total_messages = out_msg_r;

  a_report_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    is_sample && report |=> ticks_r[$past(item_ch)] == '0)
    else $error("report did not clear tick counter");

  a_report_on_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    is_sample && report |=> fill_r[$past(item_ch)] == FILL_W'(WINDOW))
    else $error("report issued on a partial window");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r))
    else $error("report beat without a report in flight");

endmodule
`default_nettype wire

// File: rtl/multichannel_window_average_reporter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_window_average_reporter_top
// sliding window average per channel with count and timeout driven reports
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one beat is a sample (mode 0, channel type, value) or a tick
//            (mode 1). samples whose type is outside base .. base+CHANNELS-1
//            are taken and dropped
//   out_ch : one report beat (channel index, average in q.8, message count)
//            for a sample that fills a window at a multiple of WINDOW
//            messages or after report_interval ticks since the last report
//   cfg_*  : write enable, register index, data; write only while idle
// throughput: one beat per cycle while no report waits on a stalled out_ch,
//   set by the ring read/write per sample and the running sum update
// path: a report passes the queue, the counter/ring stage, the sum stage and
//   the multiply into the output register
// stall: out_ch not ready while a report waits freezes the back pipeline; the
//   4-entry queue keeps taking beats until full, then in_ch.ready drops
// reset: synchronous rst_n clears counters, sums, queue and valid flags;
//   base resets to 0 and the interval to 1000000 ticks
// ----------------------------------------------------------------------------
module multichannel_window_average_reporter_top #(
  parameter int WINDOW   = mwar_pkg::WINDOW_DEFAULT,
  parameter int CHANNELS = mwar_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mwar_in_if.sink                              in_ch,
  mwar_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [mwar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mwar_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mwar_pkg::*;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = 1 + CH_W + SAMPLE_W;

  // configuration registers
  logic [TYPE_W-1:0] base_r;
  logic [TICK_W-1:0] interval_r;

  // front to queue, queue to back
  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= BASE_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_CHANNEL_TYPE: base_r     <= cfg_wdata[TYPE_W-1:0];
        CFG_REPORT_INTERVAL:   interval_r <= cfg_wdata[TICK_W-1:0];
        default:               base_r     <= base_r;
      endcase
    end
  end

  // classify and drop out-of-range samples
  mwar_front #(
    .CHANNELS (CHANNELS),
    .ENTRY_W  (ENTRY_W)
  ) u_front (
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_mode           (in_ch.mode),
    .in_channel_type   (in_ch.type_code),
    .in_sample_value   (in_ch.sample_value),
    .base_channel_type (base_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_wdata)
  );

  // decouples input acceptance from output stalls
  mwar_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  // window update, report decision and average
  mwar_back #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .report_interval    (interval_r),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_channel_index  (out_ch.channel_index),
    .out_average_q8     (out_ch.average_q8),
    .out_total_messages (out_ch.total_messages)
  );

endmodule
`default_nettype wire

// File: test/multichannel_window_average_reporter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_window_average_reporter_top_tb
// self-checking bench for the per-channel sliding window average reporter.
// a short stimulus table hits the extremes, both beat kinds, dropped types,
// a zero interval and a base at the top of the code space; random phases
// follow under several register settings and idle patterns. every accepted
// beat runs through a local window model and each report beat is compared
// field by field with the oldest expected report.
// ----------------------------------------------------------------------------
module multichannel_window_average_reporter_top_tb;
  import mwar_pkg::*;

  localparam int WIN           = WINDOW_DEFAULT;
  localparam int NCH           = CHANNELS_DEFAULT;
  localparam int POS_W         = $clog2(WIN);
  localparam int SUM_W         = SAMPLE_W + POS_W;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_BEATS   = 210;
  localparam int MAX_SHOWN     = 10;

  typedef struct packed {
    logic [CHIDX_W-1:0] chan;
    logic [AVG_W-1:0]   avg;
    logic [MSG_W-1:0]   total;
  } report_t;

  typedef enum logic {
    ROW_BEAT  = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  // one row: a register write, or a beat repeated reps times; when typed is
  // set the last repeat must give the report in want
  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              widx;
    logic [CFG_DATA_W-1:0] wdata;
    item_kind_t            mode;
    logic [TYPE_W-1:0]     ctype;
    logic [SAMPLE_W-1:0]   value;
    logic [7:0]            reps;
    logic                  typed;
    report_t               want;
  } plan_row_t;

  localparam int PLAN_ROWS = 12;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // fill channel 0 with full scale samples, the sixteenth reports the maximum
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd0, 16'hFFFF, 8'd15, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd0, 16'hFFFF, 8'd1, 1'b1,
      '{2'd0, 24'hFFFF00, 32'd16}},
    // tick with all-ones payload, the payload must not matter
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_TICK, 8'hFF, 16'hFFFF, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    // type just past the accepted range is dropped
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd4, 16'h1234, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd3, 16'hFFFF, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    // zero interval: any sample on a full window reports
    '{ROW_WRITE, CFG_REPORT_INTERVAL, 32'd0, ITEM_SAMPLE, 8'd0, 16'd0, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd0, 16'h0000, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    // base at the top of the code space, upper data bits must be masked off
    '{ROW_WRITE, CFG_BASE_CHANNEL_TYPE, 32'hA5A5_A5FC, ITEM_SAMPLE, 8'd0, 16'd0, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd255, 16'h8000, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd251, 16'h7FFF, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_SAMPLE, 8'd0, 16'h0001, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}},
    '{ROW_BEAT, CFG_BASE_CHANNEL_TYPE, 32'd0, ITEM_TICK, 8'h00, 16'h0000, 8'd1, 1'b0,
      '{2'd0, 24'd0, 32'd0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mwar_in_if  in_ch ();
  mwar_out_if out_ch ();

  multichannel_window_average_reporter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // window model: registers and per-channel state as the block should hold them
  // ---------------------------------------------------------------------------
  logic [TYPE_W-1:0]   base_type;
  logic [TICK_W-1:0]   interval_ticks;
  logic [SAMPLE_W-1:0] ring      [NCH][WIN];
  logic [POS_W-1:0]    ring_pos  [NCH];
  logic [POS_W:0]      fill      [NCH];
  logic [SUM_W-1:0]    win_sum   [NCH];
  logic [MSG_W-1:0]    msg_cnt   [NCH];
  logic [TICK_W-1:0]   tick_cnt  [NCH];

  report_t pending_reports [$];
  int      errors;
  int      cycles;
  int      sender_idle_pct;
  int      recv_stall_pct;
  bit      draining;

  // applies one accepted beat to the model, returns 1 when a report is due
  function automatic bit advance_window_state(input item_kind_t mode,
                                              input logic [TYPE_W-1:0] ctype,
                                              input logic [SAMPLE_W-1:0] value,
                                              output report_t rep);
    int rel;
    int ch;
    logic [POS_W-1:0] pos;
    rep = '0;
    if (mode == ITEM_TICK) begin
      // every channel ages, saturating at all ones
      for (int c = 0; c < NCH; c++) begin
        if (tick_cnt[c] != '1) tick_cnt[c] = tick_cnt[c] + 1'b1;
      end
      return 1'b0;
    end
    rel = int'(ctype) - int'(base_type);
    if (rel < 0 || rel >= NCH) return 1'b0;
    ch  = rel;
    pos = ring_pos[ch];
    // once full, the oldest sample drops out of the running sum
    if (fill[ch] >= WIN) begin
      win_sum[ch] = win_sum[ch] - SUM_W'(ring[ch][pos]);
    end else begin
      fill[ch] = fill[ch] + 1'b1;
    end
    ring[ch][pos] = value;
    win_sum[ch]   = win_sum[ch] + SUM_W'(value);
    ring_pos[ch]  = pos + 1'b1;
    msg_cnt[ch]   = msg_cnt[ch] + 1'b1;
    if (fill[ch] != WIN) return 1'b0;
    if (msg_cnt[ch][POS_W-1:0] != '0 && tick_cnt[ch] < interval_ticks) return 1'b0;
    tick_cnt[ch] = '0;
    rep.chan  = CHIDX_W'(ch);
    rep.avg   = AVG_W'((32'(win_sum[ch]) << 8) / WIN);
    rep.total = msg_cnt[ch];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // registers change only while nothing is in flight
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_BASE_CHANNEL_TYPE) begin
      base_type = data[TYPE_W-1:0];
    end else begin
      interval_ticks = data;
    end
  endtask

  // presents one beat, holds it until taken, then books the expected report
  task automatic send_beat(input item_kind_t mode, input logic [TYPE_W-1:0] ctype,
                           input logic [SAMPLE_W-1:0] value, input logic typed,
                           input report_t want);
    report_t rep;
    bit      due;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.type_code    <= ctype;
    in_ch.sample_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = advance_window_state(mode, ctype, value, rep);
    if (typed) begin
      pending_reports.insert(pending_reports.size(), want);
    end else if (due) begin
      pending_reports.insert(pending_reports.size(), rep);
    end
  endtask

  // drop valid, open the receiver and wait out the pipeline; dropped beats
  // give no report, so a fixed tail covers them
  task automatic settle();
    draining = 1'b1;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    draining = 1'b0;
  endtask

  // mostly samples aimed at the four channels, some ticks, some types that
  // sit just outside the accepted range or anywhere
  task automatic send_random_beat();
    int                  pick;
    int                  vsel;
    item_kind_t          mode;
    logic [TYPE_W-1:0]   ctype;
    logic [SAMPLE_W-1:0] value;
    pick  = $urandom_range(0, 99);
    vsel  = $urandom_range(0, 9);
    mode  = ITEM_SAMPLE;
    ctype = TYPE_W'($urandom());
    if (vsel == 0) begin
      value = '0;
    end else if (vsel == 1) begin
      value = '1;
    end else begin
      value = SAMPLE_W'($urandom());
    end
    if (pick < 12) begin
      mode = ITEM_TICK;
    end else if (pick < 20) begin
      case ($urandom_range(0, 2))
        0: ctype = base_type - 1'b1;
        1: ctype = base_type + TYPE_W'(NCH);
        default: ;
      endcase
    end else begin
      ctype = base_type + TYPE_W'($urandom_range(0, NCH - 1));
    end
    send_beat(mode, ctype, value, 1'b0, '0);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct,
                           input logic [TYPE_W-1:0] base, input logic [TICK_W-1:0] ival);
    settle();
    // junk in the upper data bits of the base write
    write_reg(CFG_BASE_CHANNEL_TYPE, ($urandom() & 32'hFFFF_FF00) | 32'(base));
    write_reg(CFG_REPORT_INTERVAL, ival);
    sender_idle_pct = snd_pct;
    recv_stall_pct  = rcv_pct;
    repeat (PHASE_BEATS) send_random_beat();
  endtask

  // receiver: random stalls, always ready while draining
  always @(negedge clk) begin
    out_ch.ready <= draining || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // report checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_reports
    report_t seen;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.channel_index, out_ch.average_q8, out_ch.total_messages};
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("unexpected report beat: ch %0d avg %0h total %0d",
                   seen.chan, seen.avg, seen.total);
        end
      end else begin
        want = pending_reports[0];
        pending_reports.delete(0);
        if (seen.chan !== want.chan || seen.avg !== want.avg ||
            seen.total !== want.total) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("report mismatch: expected ch %0d avg %0h total %0d,",
                     want.chan, want.avg, want.total,
                     " got ch %0d avg %0h total %0d",
                     seen.chan, seen.avg, seen.total);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.mode         = ITEM_SAMPLE;
    in_ch.type_code    = '0;
    in_ch.sample_value = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_BASE_CHANNEL_TYPE;
    cfg_wdata          = '0;
    errors             = 0;
    cycles             = 0;
    draining           = 1'b0;
    sender_idle_pct    = 0;
    recv_stall_pct     = 0;
    base_type          = BASE_RESET;
    interval_ticks     = INTERVAL_RESET;
    for (int c = 0; c < NCH; c++) begin
      ring_pos[c] = '0;
      fill[c]     = '0;
      win_sum[c]  = '0;
      msg_cnt[c]  = '0;
      tick_cnt[c] = '0;
      for (int k = 0; k < WIN; k++) ring[c][k] = '0;
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        settle();
        write_reg(PLAN[i].widx, PLAN[i].wdata);
      end else begin
        for (int k = 0; k < int'(PLAN[i].reps); k++) begin
          send_beat(PLAN[i].mode, PLAN[i].ctype, PLAN[i].value,
                    PLAN[i].typed && (k == int'(PLAN[i].reps) - 1), PLAN[i].want);
        end
      end
    end

    // random phases: idle patterns none / sender / receiver / both, register
    // settings from reset values through the extremes
    run_phase(0, 0, BASE_RESET, INTERVAL_RESET);
    run_phase(80, 0, 8'd252, 32'hFFFF_FFFF);
    run_phase(0, 80, TYPE_W'($urandom_range(1, 251)), 32'd1);
    run_phase(9, 9, TYPE_W'($urandom_range(0, 252)), 32'($urandom_range(2, 40)));
    run_phase(0, 0, 8'd0, 32'd0);
    run_phase(80, 0, TYPE_W'($urandom_range(0, 252)), 32'($urandom_range(1, 12)));
    run_phase(0, 80, 8'd252, 32'd3);
    run_phase(9, 9, TYPE_W'($urandom_range(0, 252)), 32'($urandom()));
    settle();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mwar_pkg.sv
rtl/mwar_if.sv
rtl/mwar_front.sv
rtl/mwar_queue.sv
rtl/mwar_back.sv
rtl/multichannel_window_average_reporter_top.sv
test/multichannel_window_average_reporter_top_tb.sv
